[sv/lpm_pkg.sv]
`default_nettype none
package lpm_pkg;

  localparam int CORDIC_STEPS = 16;
  localparam int FRAC_BITS    = 14;

  localparam int IN_W      = 16;
  localparam int OUT_W     = 20;
  localparam int ANG_FRAC  = 30;
  localparam int ROUND_SH  = ANG_FRAC - FRAC_BITS;
  localparam int ANG_W     = 52 - FRAC_BITS;
  localparam int AT_W      = 50 - FRAC_BITS;
  localparam int XY_W      = 33;
  localparam int SUM_W     = XY_W + 1;
  localparam int PROD_W    = 2 * XY_W;
  localparam int NUM_STAGES = 2 * CORDIC_STEPS + 6;

  localparam logic signed [ANG_W-1:0] FIX_PI       = ANG_W'(64'sd3373259426);
  localparam logic signed [ANG_W-1:0] FIX_MINUS_PI = ANG_W'(-64'sd3373259426);
  localparam logic signed [ANG_W-1:0] FIX_TWO_PI   = ANG_W'(64'sd6746518852);
  localparam logic signed [ANG_W-1:0] FIX_HALF_PI  = ANG_W'(64'sd1686629713);
  localparam logic signed [ANG_W-1:0] FIX_MINUS_HALF_PI = ANG_W'(-64'sd1686629713);
  localparam logic signed [XY_W-1:0]  FIX_GAIN     = XY_W'(64'sd652032874);

  localparam logic signed [SUM_W-1:0] OUT_MAX = SUM_W'((64'sd1 <<< (OUT_W - 1)) - 64'sd1);
  localparam logic signed [SUM_W-1:0] OUT_MIN = SUM_W'(-(64'sd1 <<< (OUT_W - 1)));
  localparam logic signed [SUM_W-1:0] ONE_S   = SUM_W'(64'sd1 <<< FRAC_BITS);
  localparam logic signed [OUT_W-1:0] ROT_BOUND =
      OUT_W'((64'sd1 <<< FRAC_BITS) + (64'sd1 <<< (FRAC_BITS - 5)));

  typedef struct packed {
    logic signed [IN_W-1:0] left_eye_x;
    logic signed [IN_W-1:0] left_eye_y;
    logic signed [IN_W-1:0] right_eye_x;
    logic signed [IN_W-1:0] right_eye_y;
    logic signed [IN_W-1:0] nose_x;
    logic signed [IN_W-1:0] nose_y;
    logic signed [IN_W-1:0] nose_z;
  } lpm_in_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] r00;
    logic signed [OUT_W-1:0] r01;
    logic signed [OUT_W-1:0] r02;
    logic signed [OUT_W-1:0] r10;
    logic signed [OUT_W-1:0] r11;
    logic signed [OUT_W-1:0] r12;
    logic signed [OUT_W-1:0] r20;
    logic signed [OUT_W-1:0] r21;
    logic signed [OUT_W-1:0] r22;
  } lpm_rot_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] shift_x;
    logic signed [OUT_W-1:0] shift_y;
    logic signed [OUT_W-1:0] shift_z;
  } lpm_shift_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] r00;
    logic signed [OUT_W-1:0] r01;
    logic signed [OUT_W-1:0] r02;
    logic signed [OUT_W-1:0] r10;
    logic signed [OUT_W-1:0] r11;
    logic signed [OUT_W-1:0] r12;
    logic signed [OUT_W-1:0] r20;
    logic signed [OUT_W-1:0] r21;
    logic signed [OUT_W-1:0] r22;
    logic signed [OUT_W-1:0] shift_x;
    logic signed [OUT_W-1:0] shift_y;
    logic signed [OUT_W-1:0] shift_z;
  } lpm_out_t;

  // atan(2^-i) in q.30, truncated toward zero
  function automatic logic signed [ANG_W-1:0] atan_q30(input int i);
    case (i)
      0:  return ANG_W'(64'sd843314856);
      1:  return ANG_W'(64'sd497837829);
      2:  return ANG_W'(64'sd263043836);
      3:  return ANG_W'(64'sd133525158);
      4:  return ANG_W'(64'sd67021686);
      5:  return ANG_W'(64'sd33543515);
      6:  return ANG_W'(64'sd16775850);
      7:  return ANG_W'(64'sd8388437);
      8:  return ANG_W'(64'sd4194282);
      9:  return ANG_W'(64'sd2097149);
      10: return ANG_W'(64'sd1048575);
      11: return ANG_W'(64'sd524287);
      12: return ANG_W'(64'sd262143);
      13: return ANG_W'(64'sd131071);
      14: return ANG_W'(64'sd65535);
      15: return ANG_W'(64'sd32767);
      16: return ANG_W'(64'sd16383);
      17: return ANG_W'(64'sd8191);
      18: return ANG_W'(64'sd4095);
      19: return ANG_W'(64'sd2047);
      20: return ANG_W'(64'sd1023);
      21: return ANG_W'(64'sd511);
      22: return ANG_W'(64'sd255);
      23: return ANG_W'(64'sd127);
      default: return '0;
    endcase
  endfunction

  function automatic logic signed [XY_W-1:0] qmul(input logic signed [XY_W-1:0] a,
                                                   input logic signed [XY_W-1:0] b);
    logic signed [PROD_W-1:0] p;
    p = a * b;
    p = p + PROD_W'(64'sd1 <<< (ANG_FRAC - 1));
    return XY_W'(p >>> ANG_FRAC);
  endfunction

  function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [SUM_W-1:0] v);
    if (v > OUT_MAX) return OUT_MAX[OUT_W-1:0];
    if (v < OUT_MIN) return OUT_MIN[OUT_W-1:0];
    return v[OUT_W-1:0];
  endfunction

  function automatic logic signed [OUT_W-1:0] q30_out(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] r;
    r = (v + SUM_W'(64'sd1 <<< (ROUND_SH - 1))) >>> ROUND_SH;
    return sat_out(r);
  endfunction

endpackage
`default_nettype wire

[sv/lpm_in_if.sv]
`default_nettype none
interface lpm_in_if;
  logic              valid;
  logic              ready;
  lpm_pkg::lpm_in_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

[sv/lpm_out_if.sv]
`default_nettype none
interface lpm_out_if;
  logic              valid;
  logic              ready;
  lpm_pkg::lpm_out_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

[sv/lpm_pipe_ctl.sv]
`default_nettype none
module lpm_pipe_ctl (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  output logic en
);
  logic [lpm_pkg::NUM_STAGES-1:0] v;

  // whole pipe advances unless the output register holds an untaken beat
  assign en        = !v[lpm_pkg::NUM_STAGES-1] || out_ready;
  assign in_ready  = en;
  assign out_valid = v[lpm_pkg::NUM_STAGES-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[lpm_pkg::NUM_STAGES-2:0], in_valid};
    end
  end
endmodule
`default_nettype wire

[sv/lpm_atan2.sv]
`default_nettype none
module lpm_atan2 (
  input  logic                             clk,
  input  logic                             en,
  input  logic signed [lpm_pkg::AT_W-1:0]  dx,
  input  logic signed [lpm_pkg::AT_W-1:0]  dy,
  output logic signed [lpm_pkg::ANG_W-1:0] angle
);
  localparam int N = lpm_pkg::CORDIC_STEPS;

  logic signed [lpm_pkg::AT_W-1:0]  x [0:N];
  logic signed [lpm_pkg::AT_W-1:0]  y [0:N];
  logic signed [lpm_pkg::ANG_W-1:0] z [0:N];
  logic                             zero [0:N];

  logic signed [lpm_pkg::AT_W-1:0]  x_in;
  logic signed [lpm_pkg::AT_W-1:0]  y_in;
  logic signed [lpm_pkg::ANG_W-1:0] z_in;

  // vector pointing left: reflect and start from +-pi
  always_comb begin
    if (dx < 0) begin
      x_in = -dx;
      y_in = -dy;
      z_in = (dy >= 0) ? lpm_pkg::FIX_PI : lpm_pkg::FIX_MINUS_PI;
    end else begin
      x_in = dx;
      y_in = dy;
      z_in = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x[0]    <= x_in;
      y[0]    <= y_in;
      z[0]    <= z_in;
      zero[0] <= (dx == 0) && (dy == 0);
      for (int i = 0; i < N; i++) begin
        if (y[i] > 0) begin
          x[i+1] <= x[i] + (y[i] >>> i);
          y[i+1] <= y[i] - (x[i] >>> i);
          z[i+1] <= z[i] + lpm_pkg::atan_q30(i);
        end else begin
          x[i+1] <= x[i] - (y[i] >>> i);
          y[i+1] <= y[i] + (x[i] >>> i);
          z[i+1] <= z[i] - lpm_pkg::atan_q30(i);
        end
        zero[i+1] <= zero[i];
      end
    end
  end

  assign angle = zero[N] ? '0 : z[N];
endmodule
`default_nettype wire

[sv/lpm_sincos.sv]
`default_nettype none
module lpm_sincos (
  input  logic                             clk,
  input  logic                             en,
  input  logic signed [lpm_pkg::ANG_W-1:0] angle,
  output logic signed [lpm_pkg::XY_W-1:0]  cos_q,
  output logic signed [lpm_pkg::XY_W-1:0]  sin_q
);
  localparam int N = lpm_pkg::CORDIC_STEPS;

  logic signed [lpm_pkg::XY_W-1:0]  x [0:N];
  logic signed [lpm_pkg::XY_W-1:0]  y [0:N];
  logic signed [lpm_pkg::ANG_W-1:0] z [0:N];
  logic                             neg [0:N];

  logic signed [lpm_pkg::ANG_W-1:0] za;
  logic signed [lpm_pkg::ANG_W-1:0] zb;
  logic signed [lpm_pkg::ANG_W-1:0] zr;
  logic                             negr;

  // two wrap passes into [-pi, pi], then fold beyond +-pi/2
  always_comb begin
    za = angle;
    if (za > lpm_pkg::FIX_PI) za = za - lpm_pkg::FIX_TWO_PI;
    else if (za < lpm_pkg::FIX_MINUS_PI) za = za + lpm_pkg::FIX_TWO_PI;
    zb = za;
    if (zb > lpm_pkg::FIX_PI) zb = zb - lpm_pkg::FIX_TWO_PI;
    else if (zb < lpm_pkg::FIX_MINUS_PI) zb = zb + lpm_pkg::FIX_TWO_PI;
    zr   = zb;
    negr = 1'b0;
    if (zb > lpm_pkg::FIX_HALF_PI) begin
      zr   = zb - lpm_pkg::FIX_PI;
      negr = 1'b1;
    end else if (zb < lpm_pkg::FIX_MINUS_HALF_PI) begin
      zr   = zb + lpm_pkg::FIX_PI;
      negr = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x[0]   <= lpm_pkg::FIX_GAIN;
      y[0]   <= '0;
      z[0]   <= zr;
      neg[0] <= negr;
      for (int i = 0; i < N; i++) begin
        if (z[i] >= 0) begin
          x[i+1] <= x[i] - (y[i] >>> i);
          y[i+1] <= y[i] + (x[i] >>> i);
          z[i+1] <= z[i] - lpm_pkg::atan_q30(i);
        end else begin
          x[i+1] <= x[i] + (y[i] >>> i);
          y[i+1] <= y[i] - (x[i] >>> i);
          z[i+1] <= z[i] + lpm_pkg::atan_q30(i);
        end
        neg[i+1] <= neg[i];
      end
    end
  end

  assign cos_q = neg[N] ? -x[N] : x[N];
  assign sin_q = neg[N] ? -y[N] : y[N];
endmodule
`default_nettype wire

[sv/lpm_matrix.sv]
`default_nettype none
module lpm_matrix (
  input  logic                            clk,
  input  logic                            en,
  input  logic signed [lpm_pkg::XY_W-1:0] cz,
  input  logic signed [lpm_pkg::XY_W-1:0] sz,
  input  logic signed [lpm_pkg::XY_W-1:0] cy,
  input  logic signed [lpm_pkg::XY_W-1:0] sy,
  input  logic signed [lpm_pkg::XY_W-1:0] cx,
  input  logic signed [lpm_pkg::XY_W-1:0] sx,
  output lpm_pkg::lpm_rot_t               rot
);
  localparam int W = lpm_pkg::XY_W;
  localparam int S = lpm_pkg::SUM_W;

  // first products
  logic signed [W-1:0] a_czcy, a_szcy, a_czsy, a_szsy, a_cysx, a_cycx;
  logic signed [W-1:0] a_szcx, a_czcx, a_czsx, a_szsx, a_sy, a_sx, a_cx;
  // second products, rest carried
  logic signed [W-1:0] b_01, b_02, b_11, b_12;
  logic signed [W-1:0] b_czcy, b_szcy, b_cysx, b_cycx, b_szcx, b_czcx, b_czsx, b_szsx, b_sy;

  always_ff @(posedge clk) begin
    if (en) begin
      a_czcy <= lpm_pkg::qmul(cz, cy);
      a_szcy <= lpm_pkg::qmul(sz, cy);
      a_czsy <= lpm_pkg::qmul(cz, sy);
      a_szsy <= lpm_pkg::qmul(sz, sy);
      a_cysx <= lpm_pkg::qmul(cy, sx);
      a_cycx <= lpm_pkg::qmul(cy, cx);
      a_szcx <= lpm_pkg::qmul(sz, cx);
      a_czcx <= lpm_pkg::qmul(cz, cx);
      a_czsx <= lpm_pkg::qmul(cz, sx);
      a_szsx <= lpm_pkg::qmul(sz, sx);
      a_sy   <= sy;
      a_sx   <= sx;
      a_cx   <= cx;

      b_01   <= lpm_pkg::qmul(a_czsy, a_sx);
      b_02   <= lpm_pkg::qmul(a_czsy, a_cx);
      b_11   <= lpm_pkg::qmul(a_szsy, a_sx);
      b_12   <= lpm_pkg::qmul(a_szsy, a_cx);
      b_czcy <= a_czcy;
      b_szcy <= a_szcy;
      b_cysx <= a_cysx;
      b_cycx <= a_cycx;
      b_szcx <= a_szcx;
      b_czcx <= a_czcx;
      b_czsx <= a_czsx;
      b_szsx <= a_szsx;
      b_sy   <= a_sy;

      rot.r00 <= lpm_pkg::q30_out(S'(b_czcy));
      rot.r01 <= lpm_pkg::q30_out(S'(b_01) - S'(b_szcx));
      rot.r02 <= lpm_pkg::q30_out(S'(b_02) + S'(b_szsx));
      rot.r10 <= lpm_pkg::q30_out(S'(b_szcy));
      rot.r11 <= lpm_pkg::q30_out(S'(b_11) + S'(b_czcx));
      rot.r12 <= lpm_pkg::q30_out(S'(b_12) - S'(b_czsx));
      rot.r20 <= lpm_pkg::q30_out(-S'(b_sy));
      rot.r21 <= lpm_pkg::q30_out(S'(b_cysx));
      rot.r22 <= lpm_pkg::q30_out(S'(b_cycx));
    end
  end
endmodule
`default_nettype wire

[sv/landmarks_to_pose_matrix.sv]
// Head pose from three face landmarks.
// landmarks (sink): one beat carries left eye, right eye and nose tip in
// signed Q2.14. pose (source): one beat per input beat, the nine entries of
// R = Rz(roll)*Ry(yaw)*Rx(pitch) and the scene translation, Q6.14 saturated.
// Yaw and pitch come from the eye midpoint and nose, roll from a vectoring
// CORDIC on the eye line; sines and cosines from rotation CORDICs.
// The pipeline is an input register, the atan2 CORDIC (prelude plus one
// stage per step), the roll sin/cos CORDIC (range reduction plus one stage
// per step), and three stages of products and rounding, the last being the
// output register. Throughput is one beat per clock while pose is not
// stalled; yaw and pitch sin/cos run beside the atan2 and wait in a
// delay line.
// Reset clears all valid bits; payload registers are not reset.
// When pose is stalled with a beat held, the whole pipe freezes and
// landmarks.ready drops in the same cycle; nothing is lost or repeated.
`default_nettype none
module landmarks_to_pose_matrix (
  input  logic              clk,
  input  logic              rst,
  lpm_in_if.sink            landmarks,
  lpm_out_if.source         pose
);
  localparam int N  = lpm_pkg::CORDIC_STEPS;
  localparam int NS = lpm_pkg::NUM_STAGES;
  localparam int AW = lpm_pkg::ANG_W;
  localparam int TW = lpm_pkg::AT_W;
  localparam int W  = lpm_pkg::XY_W;
  localparam int S  = lpm_pkg::SUM_W;

  logic en;

  lpm_pipe_ctl u_ctl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (landmarks.valid),
    .in_ready  (landmarks.ready),
    .out_valid (pose.valid),
    .out_ready (pose.ready),
    .en        (en)
  );

  // input stage: angles in q.30, eye-line vector, translation
  logic signed [AW-1:0] eye_sx, eye_sy, ny_a, yaw_c, pitch_c;
  logic signed [TW-1:0] dx_c, dy_c;
  lpm_pkg::lpm_shift_t  shift_c;

  always_comb begin
    eye_sx  = AW'(landmarks.data.left_eye_x) + AW'(landmarks.data.right_eye_x);
    eye_sy  = AW'(landmarks.data.left_eye_y) + AW'(landmarks.data.right_eye_y);
    ny_a    = AW'(landmarks.data.nose_y);
    yaw_c   = (eye_sx - (AW'(1) <<< lpm_pkg::FRAC_BITS)) <<< lpm_pkg::ROUND_SH;
    pitch_c = ((eye_sy <<< 1) + eye_sy - (ny_a <<< 2) - (ny_a <<< 1))
              <<< (lpm_pkg::ROUND_SH - 2);
    dx_c    = (TW'(landmarks.data.right_eye_x) - TW'(landmarks.data.left_eye_x))
              <<< lpm_pkg::ROUND_SH;
    dy_c    = (TW'(landmarks.data.right_eye_y) - TW'(landmarks.data.left_eye_y))
              <<< lpm_pkg::ROUND_SH;
    shift_c.shift_x = lpm_pkg::sat_out((S'(landmarks.data.nose_x) <<< 1) - lpm_pkg::ONE_S);
    shift_c.shift_y = lpm_pkg::sat_out(lpm_pkg::ONE_S - (S'(landmarks.data.nose_y) <<< 1));
    shift_c.shift_z = lpm_pkg::sat_out(S'(landmarks.data.nose_z) + lpm_pkg::ONE_S);
  end

  logic signed [AW-1:0] yaw, pitch;
  logic signed [TW-1:0] dx, dy;
  lpm_pkg::lpm_shift_t  shift_d [0:NS-1];

  always_ff @(posedge clk) begin
    if (en) begin
      yaw        <= yaw_c;
      pitch      <= pitch_c;
      dx         <= dx_c;
      dy         <= dy_c;
      shift_d[0] <= shift_c;
      for (int k = 1; k < NS; k++) begin
        shift_d[k] <= shift_d[k-1];
      end
    end
  end

  logic signed [AW-1:0] roll;
  logic signed [W-1:0]  cy_o, sy_o, cx_o, sx_o, cz, sz;

  lpm_atan2 u_atan2 (.clk(clk), .en(en), .dx(dx), .dy(dy), .angle(roll));

  lpm_sincos u_yaw   (.clk(clk), .en(en), .angle(yaw),   .cos_q(cy_o), .sin_q(sy_o));
  lpm_sincos u_pitch (.clk(clk), .en(en), .angle(pitch), .cos_q(cx_o), .sin_q(sx_o));
  lpm_sincos u_roll  (.clk(clk), .en(en), .angle(roll),  .cos_q(cz),   .sin_q(sz));

  // yaw and pitch wait while roll goes through its sin/cos
  logic signed [W-1:0] cy_d [0:N];
  logic signed [W-1:0] sy_d [0:N];
  logic signed [W-1:0] cx_d [0:N];
  logic signed [W-1:0] sx_d [0:N];

  always_ff @(posedge clk) begin
    if (en) begin
      cy_d[0] <= cy_o;
      sy_d[0] <= sy_o;
      cx_d[0] <= cx_o;
      sx_d[0] <= sx_o;
      for (int k = 1; k <= N; k++) begin
        cy_d[k] <= cy_d[k-1];
        sy_d[k] <= sy_d[k-1];
        cx_d[k] <= cx_d[k-1];
        sx_d[k] <= sx_d[k-1];
      end
    end
  end

  lpm_pkg::lpm_rot_t rot;

  lpm_matrix u_matrix (
    .clk (clk),
    .en  (en),
    .cz  (cz),
    .sz  (sz),
    .cy  (cy_d[N]),
    .sy  (sy_d[N]),
    .cx  (cx_d[N]),
    .sx  (sx_d[N]),
    .rot (rot)
  );

  always_comb begin
    pose.data.r00     = rot.r00;
    pose.data.r01     = rot.r01;
    pose.data.r02     = rot.r02;
    pose.data.r10     = rot.r10;
    pose.data.r11     = rot.r11;
    pose.data.r12     = rot.r12;
    pose.data.r20     = rot.r20;
    pose.data.r21     = rot.r21;
    pose.data.r22     = rot.r22;
    pose.data.shift_x = shift_d[NS-1].shift_x;
    pose.data.shift_y = shift_d[NS-1].shift_y;
    pose.data.shift_z = shift_d[NS-1].shift_z;
  end

`ifndef NO_ASSERTIONS
  assert property (@(posedge clk) rst |=> !pose.valid)
    else $error("pose beat valid right after reset");

  assert property (@(posedge clk) disable iff (rst)
    pose.valid |-> (pose.data.r00 <= lpm_pkg::ROT_BOUND) &&
                   (pose.data.r00 >= -lpm_pkg::ROT_BOUND) &&
                   (pose.data.r11 <= lpm_pkg::ROT_BOUND) &&
                   (pose.data.r11 >= -lpm_pkg::ROT_BOUND) &&
                   (pose.data.r22 <= lpm_pkg::ROT_BOUND) &&
                   (pose.data.r22 >= -lpm_pkg::ROT_BOUND))
    else $error("rotation diagonal out of unit range");

  assert property (@(posedge clk) disable iff (rst)
    pose.valid |-> (pose.data.r20 <= lpm_pkg::ROT_BOUND) &&
                   (pose.data.r20 >= -lpm_pkg::ROT_BOUND) &&
                   (pose.data.r21 <= lpm_pkg::ROT_BOUND) &&
                   (pose.data.r21 >= -lpm_pkg::ROT_BOUND))
    else $error("rotation bottom row out of unit range");
`endif
endmodule
`default_nettype wire
